FILE: rtl/core/chsc_pkg.sv
// ----------------------------------------------------------------------------
// Chebyshev sine/cosine package
// Field widths, coefficient constants held at 24 fraction bits, and the
// rounding function that brings them to the working fraction width.
// ----------------------------------------------------------------------------
package chsc_pkg;

    localparam int ANGLE_W    = 19;
    localparam int OUT_W      = 18;
    localparam int CONST_FRAC = 24;

    localparam longint OUT_MAX = 64'sd131071;
    localparam longint OUT_MIN = -64'sd131072;

    localparam longint TWO_PI_24 = 64'sd105414357;
    localparam longint INV_PI_24 = 64'sd5340354;
    localparam longint C_T0_24   = 64'sd5103698;
    localparam longint C_T2_24   = 64'sd16311825;
    localparam longint C_T4_24   = -64'sd5569088;
    localparam longint S_T1_24   = -64'sd9550105;
    localparam longint S_T3_24   = 64'sd11193241;
    localparam longint S_T5_24   = -64'sd1864353;

    typedef logic [ANGLE_W-1:0]       angle_t;
    typedef logic signed [OUT_W-1:0]  result_t;

    // Rounds a constant with 24 fraction bits to frac fraction bits, ties up.
    function automatic longint to_frac(input longint c, input int frac);
        int sh;
        sh = CONST_FRAC - frac;
        if (sh <= 0)
        begin
            return c;
        end
        return (c + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

endpackage

FILE: rtl/core/chsc_scale.sv
// ----------------------------------------------------------------------------
// Angle scaling
// Clamps the angle to 2*pi, multiplies by 1/pi and subtracts one to give
// t in [-1, 1] (one LSB over 1 at the clamp); two register stages.
// ----------------------------------------------------------------------------
module chsc_scale #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    valid_in,
    input  chsc_pkg::angle_t        angle,
    output logic                    valid_out,
    output logic signed [FRAC_BITS+2:0] t_out
);
    import chsc_pkg::*;

    localparam int TW = FRAC_BITS + 3;
    localparam int PW = ANGLE_W + FRAC_BITS;
    localparam logic [63:0] TWO_PI = 64'(to_frac(TWO_PI_24, FRAC_BITS));
    localparam logic [FRAC_BITS-1:0] INV_PI = FRAC_BITS'(to_frac(INV_PI_24, FRAC_BITS));
    localparam logic signed [TW-1:0] ONE = TW'(64'sd1 <<< FRAC_BITS);

    logic                 valid1_reg;
    logic [PW-1:0]        prod_reg;
    logic [PW-1:0]        prod_next;
    logic                 valid2_reg;
    logic signed [TW-1:0] t_reg;
    logic signed [TW-1:0] t_next;
    angle_t               a_clamp;
    logic [PW-1:0]        quot;

    always_comb
    begin
        a_clamp   = (64'(angle) > TWO_PI) ? TWO_PI[ANGLE_W-1:0] : angle;
        prod_next = PW'(a_clamp) * PW'(INV_PI);
        quot      = prod_reg >> FRAC_BITS;
        t_next    = signed'(TW'(quot)) - ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= valid_in;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            t_reg    <= t_next;
        end
    end

    assign valid_out = valid2_reg;
    assign t_out     = t_reg;

endmodule

FILE: rtl/core/chsc_step.sv
// ----------------------------------------------------------------------------
// Chebyshev recurrence stage
// Forms T(n) = 2t*T(n-1) - T(n-2) and adds the coefficient term of T(n-1)
// to the cosine or sine sum; one register stage.
// ----------------------------------------------------------------------------
module chsc_step #(
    parameter int     FRAC_BITS = 16,
    parameter longint COEF_24   = 64'sd0,
    parameter bit     TO_COS    = 1'b0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        valid_in,
    input  logic signed [FRAC_BITS+2:0] t_in,
    input  logic signed [FRAC_BITS+2:0] a_in,
    input  logic signed [FRAC_BITS+2:0] b_in,
    input  logic signed [FRAC_BITS+3:0] cos_in,
    input  logic signed [FRAC_BITS+3:0] sin_in,
    output logic                        valid_out,
    output logic signed [FRAC_BITS+2:0] t_out,
    output logic signed [FRAC_BITS+2:0] a_out,
    output logic signed [FRAC_BITS+2:0] b_out,
    output logic signed [FRAC_BITS+3:0] cos_out,
    output logic signed [FRAC_BITS+3:0] sin_out
);
    import chsc_pkg::*;

    localparam int TW  = FRAC_BITS + 3;
    localparam int ACW = TW + 1;
    localparam int CW  = FRAC_BITS + 1;
    localparam logic signed [CW-1:0] COEF = CW'(to_frac(COEF_24, FRAC_BITS));

    logic signed [TW:0]       t2;
    logic signed [2*TW:0]     rprod;
    logic signed [2*TW:0]     rshift;
    logic signed [TW-1:0]     rtrunc;
    logic signed [CW+TW-1:0]  cprod;
    logic signed [CW+TW-1:0]  cshift;
    logic signed [TW-1:0]     term;
    logic signed [ACW-1:0]    term_ext;

    logic                     valid_reg;
    logic signed [TW-1:0]     t_reg;
    logic signed [TW-1:0]     a_reg;
    logic signed [TW-1:0]     a_next;
    logic signed [TW-1:0]     b_reg;
    logic signed [ACW-1:0]    cos_reg;
    logic signed [ACW-1:0]    cos_next;
    logic signed [ACW-1:0]    sin_reg;
    logic signed [ACW-1:0]    sin_next;

    always_comb
    begin
        t2       = {t_in, 1'b0};
        rprod    = t2 * a_in;
        rshift   = rprod >>> FRAC_BITS;
        rtrunc   = rshift[TW-1:0];
        a_next   = rtrunc - b_in;
        cprod    = COEF * a_in;
        cshift   = cprod >>> FRAC_BITS;
        term     = cshift[TW-1:0];
        term_ext = {term[TW-1], term};
        cos_next = TO_COS ? (cos_in + term_ext) : cos_in;
        sin_next = TO_COS ? sin_in : (sin_in + term_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg   <= t_in;
            a_reg   <= a_next;
            b_reg   <= a_in;
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign valid_out = valid_reg;
    assign t_out     = t_reg;
    assign a_out     = a_reg;
    assign b_out     = b_reg;
    assign cos_out   = cos_reg;
    assign sin_out   = sin_reg;

endmodule

FILE: rtl/core/chsc_final.sv
// ----------------------------------------------------------------------------
// Final sum and output register
// Adds the T5 term to the sine sum, saturates both results to the output
// range and holds them in the output register.
// ----------------------------------------------------------------------------
module chsc_final #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        valid_in,
    input  logic signed [FRAC_BITS+2:0] p5_in,
    input  logic signed [FRAC_BITS+3:0] cos_in,
    input  logic signed [FRAC_BITS+3:0] sin_in,
    output logic                        valid_out,
    output chsc_pkg::result_t           cosine,
    output chsc_pkg::result_t           sine
);
    import chsc_pkg::*;

    localparam int TW  = FRAC_BITS + 3;
    localparam int ACW = TW + 1;
    localparam int CW  = FRAC_BITS + 1;
    localparam logic signed [CW-1:0] COEF = CW'(to_frac(S_T5_24, FRAC_BITS));

    logic signed [CW+TW-1:0] cprod;
    logic signed [CW+TW-1:0] cshift;
    logic signed [TW-1:0]    term;
    logic signed [ACW-1:0]   sin_sum;
    longint                  cos_l;
    longint                  sin_l;

    logic                    valid_reg;
    result_t                 cos_reg;
    result_t                 cos_next;
    result_t                 sin_reg;
    result_t                 sin_next;

    always_comb
    begin
        cprod   = COEF * p5_in;
        cshift  = cprod >>> FRAC_BITS;
        term    = cshift[TW-1:0];
        sin_sum = sin_in + {term[TW-1], term};
        cos_l   = longint'(cos_in);
        sin_l   = longint'(sin_sum);
        if (cos_l > OUT_MAX)
        begin
            cos_next = OUT_W'(OUT_MAX);
        end
        else if (cos_l < OUT_MIN)
        begin
            cos_next = OUT_W'(OUT_MIN);
        end
        else
        begin
            cos_next = OUT_W'(cos_l);
        end
        if (sin_l > OUT_MAX)
        begin
            sin_next = OUT_W'(OUT_MAX);
        end
        else if (sin_l < OUT_MIN)
        begin
            sin_next = OUT_W'(OUT_MIN);
        end
        else
        begin
            sin_next = OUT_W'(sin_l);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign valid_out = valid_reg;
    assign cosine    = cos_reg;
    assign sine      = sin_reg;

endmodule

FILE: rtl/core/chebyshev_sine_cosine.sv
// Throughput: one item per cycle while no result waits under out_stall; one multiplier pass per stage sets the depth.
// The whole pipeline holds while a result waits under out_stall.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// Chebyshev sine/cosine top level
// Scales the angle, runs the T0..T5 recurrence in four stages while
// accumulating the cosine and sine terms, and saturates the results.
// ----------------------------------------------------------------------------
module chebyshev_sine_cosine #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  chsc_pkg::angle_t  angle,
    output logic              out_valid,
    input  logic              out_stall,
    output chsc_pkg::result_t cosine,
    output chsc_pkg::result_t sine
);
    import chsc_pkg::*;

    localparam int TW    = FRAC_BITS + 3;
    localparam int ACW   = TW + 1;
    localparam int NSTEP = 4;
    localparam logic signed [TW-1:0]  ONE     = TW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [ACW-1:0] COS_T0  = ACW'(to_frac(C_T0_24, FRAC_BITS));

    logic                   en;
    logic                   v   [NSTEP+1];
    logic signed [TW-1:0]   t   [NSTEP+1];
    logic signed [TW-1:0]   pa  [NSTEP+1];
    logic signed [TW-1:0]   pb  [NSTEP+1];
    logic signed [ACW-1:0]  cs  [NSTEP+1];
    logic signed [ACW-1:0]  sn  [NSTEP+1];

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    chsc_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (in_valid),
        .angle     (angle),
        .valid_out (v[0]),
        .t_out     (t[0])
    );

    // T1 = t and T0 = 1; the T0 cosine term is the coefficient itself.
    assign pa[0] = t[0];
    assign pb[0] = ONE;
    assign cs[0] = COS_T0;
    assign sn[0] = '0;

    chsc_step #(.FRAC_BITS(FRAC_BITS), .COEF_24(S_T1_24), .TO_COS(1'b0)) u_step1 (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(v[0]),
        .t_in(t[0]), .a_in(pa[0]), .b_in(pb[0]), .cos_in(cs[0]), .sin_in(sn[0]),
        .valid_out(v[1]), .t_out(t[1]), .a_out(pa[1]), .b_out(pb[1]),
        .cos_out(cs[1]), .sin_out(sn[1])
    );

    chsc_step #(.FRAC_BITS(FRAC_BITS), .COEF_24(C_T2_24), .TO_COS(1'b1)) u_step2 (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(v[1]),
        .t_in(t[1]), .a_in(pa[1]), .b_in(pb[1]), .cos_in(cs[1]), .sin_in(sn[1]),
        .valid_out(v[2]), .t_out(t[2]), .a_out(pa[2]), .b_out(pb[2]),
        .cos_out(cs[2]), .sin_out(sn[2])
    );

    chsc_step #(.FRAC_BITS(FRAC_BITS), .COEF_24(S_T3_24), .TO_COS(1'b0)) u_step3 (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(v[2]),
        .t_in(t[2]), .a_in(pa[2]), .b_in(pb[2]), .cos_in(cs[2]), .sin_in(sn[2]),
        .valid_out(v[3]), .t_out(t[3]), .a_out(pa[3]), .b_out(pb[3]),
        .cos_out(cs[3]), .sin_out(sn[3])
    );

    chsc_step #(.FRAC_BITS(FRAC_BITS), .COEF_24(C_T4_24), .TO_COS(1'b1)) u_step4 (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(v[3]),
        .t_in(t[3]), .a_in(pa[3]), .b_in(pb[3]), .cos_in(cs[3]), .sin_in(sn[3]),
        .valid_out(v[4]), .t_out(t[4]), .a_out(pa[4]), .b_out(pb[4]),
        .cos_out(cs[4]), .sin_out(sn[4])
    );

    chsc_final #(.FRAC_BITS(FRAC_BITS)) u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (v[NSTEP]),
        .p5_in     (pa[NSTEP]),
        .cos_in    (cs[NSTEP]),
        .sin_in    (sn[NSTEP]),
        .valid_out (out_valid),
        .cosine    (cosine),
        .sine      (sine)
    );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chebyshev sine/cosine testbench
// Streams angles through the block under random idling on both sides.
// The directed table covers zero, the quadrant points, the top of the range,
// and the angles that clamp. A random stream follows.
// Results other than the typed-in zero row are checked against a fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench;

    import chsc_pkg::*;

    localparam int FRAC       = 16;
    localparam int N_RANDOM   = 450;
    localparam int QUIET_TAIL = 60;
    localparam int PIPE_DEPTH = 7;
    localparam int ANGLE_TOP  = 411775;
    localparam int N_DIRECTED = 18;

    typedef struct packed {
        angle_t  angle;
        logic    known;
        result_t cos_v;
        result_t sin_v;
    } angle_row_t;

    typedef struct {
        angle_t  angle;
        result_t cos_v;
        result_t sin_v;
    } trig_pair_t;

    // Only the zero angle has its result typed in; there every T(n) is exactly plus or minus one.
    angle_row_t directed_rows [N_DIRECTED] = '{
        '{19'd0,      1'b1, 18'sd61900, 18'sd864},
        '{19'd1,      1'b0, 18'sd0,     18'sd0},
        '{19'd2,      1'b0, 18'sd0,     18'sd0},
        '{19'd65535,  1'b0, 18'sd0,     18'sd0},
        '{19'd65536,  1'b0, 18'sd0,     18'sd0},
        '{19'd102944, 1'b0, 18'sd0,     18'sd0},
        '{19'd131072, 1'b0, 18'sd0,     18'sd0},
        '{19'd174762, 1'b0, 18'sd0,     18'sd0},
        '{19'd205887, 1'b0, 18'sd0,     18'sd0},
        '{19'd205888, 1'b0, 18'sd0,     18'sd0},
        '{19'd262144, 1'b0, 18'sd0,     18'sd0},
        '{19'd308831, 1'b0, 18'sd0,     18'sd0},
        '{19'd349525, 1'b0, 18'sd0,     18'sd0},
        '{19'd411774, 1'b0, 18'sd0,     18'sd0},
        '{19'd411775, 1'b0, 18'sd0,     18'sd0},
        '{19'd411776, 1'b0, 18'sd0,     18'sd0},
        '{19'd500000, 1'b0, 18'sd0,     18'sd0},
        '{19'd524287, 1'b0, 18'sd0,     18'sd0}
    };

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    in_valid  = 1'b0;
    logic    out_stall = 1'b0;
    angle_t  angle     = '0;
    logic    in_stall;
    logic    out_valid;
    result_t cosine;
    result_t sine;

    angle_row_t angle_list [$];
    trig_pair_t pending_sincos [$];
    int         nxt        = 0;
    int         gap_left   = 0;
    int         stall_left = 0;
    int         pause_at   = N_DIRECTED + 200;
    bit         pause_done = 1'b0;
    int         errors     = 0;

    chebyshev_sine_cosine #(
        .FRAC_BITS(FRAC)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .angle(angle),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cosine(cosine),
        .sine(sine)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint q24_to_frac(input longint c);
        return (c + (64'sd1 <<< (23 - FRAC))) >>> (24 - FRAC);
    endfunction

    function automatic result_t clamp_out(input longint v);
        if (v > OUT_MAX)
        begin
            return result_t'(OUT_MAX);
        end
        if (v < OUT_MIN)
        begin
            return result_t'(OUT_MIN);
        end
        return result_t'(v);
    endfunction

    function automatic trig_pair_t predict_sincos(input angle_t a);
        longint     one;
        longint     x;
        longint     limit;
        longint     t;
        longint     t2x;
        longint     p2;
        longint     p3;
        longint     p4;
        longint     p5;
        longint     c;
        longint     s;
        trig_pair_t r;
        one   = 64'sd1 <<< FRAC;
        x     = longint'({1'b0, a});
        limit = q24_to_frac(TWO_PI_24);
        if (x > limit)
        begin
            x = limit;
        end
        t   = ((x * q24_to_frac(INV_PI_24)) >>> FRAC) - one;
        t2x = 2 * t;
        p2  = ((t2x * t) >>> FRAC) - one;
        p3  = ((t2x * p2) >>> FRAC) - t;
        p4  = ((t2x * p3) >>> FRAC) - p2;
        p5  = ((t2x * p4) >>> FRAC) - p3;
        c   = ((q24_to_frac(C_T0_24) * one) >>> FRAC)
            + ((q24_to_frac(C_T2_24) * p2) >>> FRAC)
            + ((q24_to_frac(C_T4_24) * p4) >>> FRAC);
        s   = ((q24_to_frac(S_T1_24) * t) >>> FRAC)
            + ((q24_to_frac(S_T3_24) * p3) >>> FRAC)
            + ((q24_to_frac(S_T5_24) * p5) >>> FRAC);
        r.angle = a;
        r.cos_v = clamp_out(c);
        r.sin_v = clamp_out(s);
        return r;
    endfunction

    always @(posedge clk)
    begin : handshake
        trig_pair_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_sincos.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected: cosine %0d sine %0d",
                             $time, cosine, sine);
                end
                else
                begin
                    want = pending_sincos.pop_front();
                    if (cosine !== want.cos_v)
                    begin
                        errors++;
                        $display("%0t: angle %0d cosine expected %0d actual %0d",
                                 $time, want.angle, want.cos_v, cosine);
                    end
                    if (sine !== want.sin_v)
                    begin
                        errors++;
                        $display("%0t: angle %0d sine expected %0d actual %0d",
                                 $time, want.angle, want.sin_v, sine);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (angle_list[nxt].known)
                begin
                    want.angle = angle;
                    want.cos_v = angle_list[nxt].cos_v;
                    want.sin_v = angle_list[nxt].sin_v;
                end
                else
                begin
                    want = predict_sincos(angle);
                end
                pending_sincos.push_back(want);
                nxt++;
            end

            if (!(in_valid && in_stall))
            begin
                if (nxt >= angle_list.size())
                begin
                    in_valid <= 1'b0;
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (nxt == pause_at && !pause_done && pending_sincos.size() != 0)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    if (nxt == pause_at)
                    begin
                        pause_done = 1'b1;
                    end
                    in_valid <= 1'b1;
                    angle    <= angle_list[nxt].angle;
                    if (nxt < angle_list.size() - QUIET_TAIL && $urandom_range(0, 3) == 0)
                    begin
                        gap_left = $urandom_range(1, 5);
                    end
                end
            end

            if (nxt >= angle_list.size() - QUIET_TAIL)
            begin
                stall_left = 0;
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : run
        angle_row_t row;
        int         sel;
        for (int k = 0; k < N_DIRECTED; k++)
        begin
            angle_list.push_back(directed_rows[k]);
        end
        for (int k = 0; k < N_RANDOM; k++)
        begin
            sel = $urandom_range(0, 9);
            row = '0;
            if (sel < 7)
            begin
                row.angle = angle_t'($urandom_range(0, ANGLE_TOP));
            end
            else if (sel == 7)
            begin
                row.angle = angle_t'($urandom_range(ANGLE_TOP + 1, 524287));
            end
            else if (sel == 8)
            begin
                row.angle = angle_t'($urandom_range(0, 63));
            end
            else
            begin
                row.angle = angle_t'($urandom_range(ANGLE_TOP - 63, ANGLE_TOP));
            end
            angle_list.push_back(row);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (nxt < angle_list.size() || in_valid || pending_sincos.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4 * PIPE_DEPTH) @(posedge clk);

        if (errors == 0 && pending_sincos.size() == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
